@@ src/spq_pkg.sv @@
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LIST   = 2'd1,
      CMD_POP    = 2'd2,
      CMD_BAD    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_BADCMD = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LIST
   } state_type;

   // where the response register takes its data from
   typedef enum logic [1:0] {
      RSP_FLAG,
      RSP_HEAD,
      RSP_ENTRY
   } rsp_src_type;

   typedef struct packed {
      logic        load_req;
      logic        do_insert;
      logic        do_pop;
      logic        list_step;
      logic        rsp_load;
      rsp_src_type rsp_src;
      status_type  rsp_status;
   } dp_ctrl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    empty;
      logic    full;
      logic    list_last;
      logic    out_free;
   } dp_stat_type;

endpackage

@@ src/spq_if.sv @@
`timescale 1ns / 1ps

interface spq_req_if;
   logic                                valid;
   logic                                ready;
   spq_pkg::cmd_type                    command;
   logic [spq_pkg::DATA_W-1:0]          payload;
   logic signed [spq_pkg::DATA_W-1:0]   priority_req;

   modport source (output valid, output command, output payload, output priority_req,
                   input ready);
   modport sink (input valid, input command, input payload, input priority_req,
                 output ready);
endinterface

interface spq_rsp_if;
   logic                                valid;
   logic                                ready;
   spq_pkg::status_type                 status;
   logic [spq_pkg::DATA_W-1:0]          out_payload;
   logic signed [spq_pkg::DATA_W-1:0]   out_priority;
   logic                                is_last;

   modport source (output valid, output status, output out_payload, output out_priority,
                   output is_last, input ready);
   modport sink (input valid, input status, input out_payload, input out_priority,
                 input is_last, output ready);
endinterface

@@ src/spq_ctrl.sv @@
`timescale 1ns / 1ps

module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  spq_pkg::dp_stat_type stat,
   output spq_pkg::dp_ctrl_type ctrl
);
   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      ctrl            = '0;
      ctrl.rsp_src    = RSP_FLAG;
      ctrl.rsp_status = STAT_OK;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               ctrl.load_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               ctrl.rsp_load = 1'b1;
               state_in      = S_IDLE;
               case (stat.cmd)
                  CMD_INSERT: begin
                     if (stat.full) begin
                        ctrl.rsp_status = STAT_FULL;
                     end else begin
                        ctrl.do_insert = 1'b1;
                     end
                  end
                  CMD_LIST: begin
                     if (stat.empty) begin
                        ctrl.rsp_status = STAT_EMPTY;
                     end else begin
                        ctrl.rsp_src   = RSP_ENTRY;
                        ctrl.list_step = 1'b1;
                        if (!stat.list_last) begin
                           state_in = S_LIST;
                        end
                     end
                  end
                  CMD_POP: begin
                     if (stat.empty) begin
                        ctrl.rsp_status = STAT_EMPTY;
                     end else begin
                        ctrl.rsp_src = RSP_HEAD;
                        ctrl.do_pop  = 1'b1;
                     end
                  end
                  default: begin
                     ctrl.rsp_status = STAT_BADCMD;
                  end
               endcase
            end
         end
         S_LIST: begin
            if (stat.out_free) begin
               ctrl.rsp_load  = 1'b1;
               ctrl.rsp_src   = RSP_ENTRY;
               ctrl.list_step = 1'b1;
               if (stat.list_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ src/spq_datapath.sv @@
`timescale 1ns / 1ps

module spq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  spq_pkg::dp_ctrl_type              ctrl,
   output spq_pkg::dp_stat_type              stat,
   input  spq_pkg::cmd_type                  req_command,
   input  logic [spq_pkg::DATA_W-1:0]        req_payload,
   input  logic signed [spq_pkg::DATA_W-1:0] req_priority,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output spq_pkg::status_type               rsp_status,
   output logic [spq_pkg::DATA_W-1:0]        rsp_payload,
   output logic signed [spq_pkg::DATA_W-1:0] rsp_priority,
   output logic                              rsp_last
);
   import spq_pkg::*;

   // latched request
   cmd_type                  cmd_ff;
   logic [DATA_W-1:0]        pay_ff;
   logic signed [DATA_W-1:0] pri_ff;

   // sorted slots, head at index 0
   logic [DATA_W-1:0]        slot_pay_ff [DEPTH];
   logic signed [DATA_W-1:0] slot_pri_ff [DEPTH];
   logic [DATA_W-1:0]        prev_pay [DEPTH];
   logic signed [DATA_W-1:0] prev_pri [DEPTH];
   logic [DATA_W-1:0]        next_pay [DEPTH];
   logic signed [DATA_W-1:0] next_pri [DEPTH];

   logic [CNT_W-1:0] fill_count_ff;
   logic [CNT_W-1:0] fill_count_in;
   logic [IDX_W-1:0] list_idx_ff;
   logic [IDX_W-1:0] list_idx_in;

   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic [DATA_W-1:0]        rsp_pay_ff;
   logic signed [DATA_W-1:0] rsp_pri_ff;
   logic                     rsp_last_ff;

   logic [DEPTH-1:0] ge;
   logic [DEPTH-1:0] ge_prev;
   logic             list_last;

   // neighbor wiring for the shift paths
   for (genvar g = 0; g < DEPTH; g++) begin : g_nb
      if (g == 0) begin : g_first
         assign prev_pay[g] = '0;
         assign prev_pri[g] = '0;
      end else begin : g_mid
         assign prev_pay[g] = slot_pay_ff[g-1];
         assign prev_pri[g] = slot_pri_ff[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign next_pay[g] = slot_pay_ff[g];
         assign next_pri[g] = slot_pri_ff[g];
      end else begin : g_inner
         assign next_pay[g] = slot_pay_ff[g+1];
         assign next_pri[g] = slot_pri_ff[g+1];
      end
   end

   // ge marks occupied slots that stay ahead of the new entry (ties keep arrival order)
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ge[i] = (CNT_W'(i) < fill_count_ff) && (slot_pri_ff[i] >= pri_ff);
      end
      ge_prev = {ge[DEPTH-2:0], 1'b1};
   end

   assign list_last = (CNT_W'(list_idx_ff) + CNT_W'(1)) == fill_count_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         cmd_ff <= req_command;
         pay_ff <= req_payload;
         pri_ff <= req_priority;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (ctrl.do_insert && !ge[i]) begin
            if (ge_prev[i]) begin
               slot_pay_ff[i] <= pay_ff;
               slot_pri_ff[i] <= pri_ff;
            end else begin
               slot_pay_ff[i] <= prev_pay[i];
               slot_pri_ff[i] <= prev_pri[i];
            end
         end else if (ctrl.do_pop) begin
            slot_pay_ff[i] <= next_pay[i];
            slot_pri_ff[i] <= next_pri[i];
         end
      end
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      if (ctrl.do_insert) begin
         fill_count_in = fill_count_ff + CNT_W'(1);
      end else if (ctrl.do_pop) begin
         fill_count_in = fill_count_ff - CNT_W'(1);
      end
      list_idx_in = list_idx_ff;
      if (ctrl.list_step) begin
         list_idx_in = list_last ? '0 : list_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         list_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         list_idx_ff   <= list_idx_in;
         if (ctrl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         case (ctrl.rsp_src)
            RSP_HEAD: begin
               rsp_status_ff <= STAT_OK;
               rsp_pay_ff    <= slot_pay_ff[0];
               rsp_pri_ff    <= slot_pri_ff[0];
               rsp_last_ff   <= 1'b1;
            end
            RSP_ENTRY: begin
               rsp_status_ff <= STAT_OK;
               rsp_pay_ff    <= slot_pay_ff[list_idx_ff];
               rsp_pri_ff    <= slot_pri_ff[list_idx_ff];
               rsp_last_ff   <= list_last;
            end
            default: begin
               rsp_status_ff <= ctrl.rsp_status;
               rsp_pay_ff    <= '0;
               rsp_pri_ff    <= '0;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign stat.cmd       = cmd_ff;
   assign stat.empty     = fill_count_ff == '0;
   assign stat.full      = fill_count_ff == CNT_W'(DEPTH);
   assign stat.list_last = list_last;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_payload  = rsp_pay_ff;
   assign rsp_priority = rsp_pri_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

@@ src/sorted_priority_queue.sv @@
// sequence: a request is latched in the idle state and its first result is registered from
//   the execute state once the result register is free (insert, pop, empty, bad command)
// throughput: a request is executed before the next is taken; a list streams one entry
//   per cycle from the slot read mux while the result register is free; a stalled result adds its wait
// reset: synchronous, active high; clears the state machine, fill count, list index and
//   result valid (slot contents are left as they are and are only read below the fill count)
`timescale 1ns / 1ps

module sorted_priority_queue (
   input logic   clock,
   input logic   reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);
   import spq_pkg::*;

   // command and status between the controller and the datapath
   dp_ctrl_type ctrl;
   dp_stat_type stat;

   // controller: idle / execute / list-stream sequencer
   //   idle takes a request, execute runs insert, pop or the first list entry,
   //   list keeps streaming one entry per free output slot
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // datapath: sorted slot registers with parallel compare for the insert point,
   // neighbor shifts for insert and pop, and the result register that decouples
   // the result side so a new request can be taken while a result waits
   spq_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .stat         (stat),
      .req_command  (req_ch.command),
      .req_payload  (req_ch.payload),
      .req_priority (req_ch.priority_req),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_status   (rsp_ch.status),
      .rsp_payload  (rsp_ch.out_payload),
      .rsp_priority (rsp_ch.out_priority),
      .rsp_last     (rsp_ch.is_last)
   );

endmodule

@@ src/spq_checker.sv @@
`timescale 1ns / 1ps

module spq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input spq_pkg::status_type               rsp_status,
   input logic [spq_pkg::DATA_W-1:0]        rsp_payload,
   input logic signed [spq_pkg::DATA_W-1:0] rsp_priority,
   input logic                              rsp_last
);
   import spq_pkg::*;

   // one request in flight: no request is taken in the cycle after one
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken back to back");

   // only a listed entry can be followed by more items of the same request
   a_not_last_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == STAT_OK))
      else $error("non-final item without ok status");

   // error items carry no entry and end the request
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |->
         (rsp_payload == '0 && rsp_priority == '0 && rsp_last))
      else $error("error item carries data");

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_payload) && $stable(rsp_priority) && $stable(rsp_last)))
      else $error("stalled item changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_status   (rsp_ch.status),
   .rsp_payload  (rsp_ch.out_payload),
   .rsp_priority (rsp_ch.out_priority),
   .rsp_last     (rsp_ch.is_last)
);
